// ===== rtl/premultiplied_bilinear_blend_defines.svh =====
// Assertion macros shared by the premultiplied bilinear blend RTL.
`ifndef PREMULTIPLIED_BILINEAR_BLEND_DEFINES_SVH
`define PREMULTIPLIED_BILINEAR_BLEND_DEFINES_SVH
`ifndef SYNTHESIS
`define PBB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PBB_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBB_ASSERT(lbl, prop, msg)
`define PBB_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== rtl/pbb_pkg.sv =====
// Package with widths, result type and helpers for the premultiplied bilinear blend.
package pbb_pkg;

	localparam int PIX_W         = 32;
	localparam int CH_W          = 8;
	localparam int FRAC_W        = 8;
	localparam int CORNERS       = 4;
	localparam int COLORS        = 3;
	localparam int ALPHA_IDX     = 3;
	localparam int QUOT_BITS     = 8;
	localparam int DEF_FRAC_BITS = 8;
	localparam int S_TDATA_W     = CORNERS * PIX_W + 2 * FRAC_W;
	localparam int M_TDATA_W     = 4 * CH_W;
	localparam int PIPE_LAT      = 4 + QUOT_BITS + 1;
	localparam int FIFO_DEPTH    = 16;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

	localparam logic [CH_W-1:0] CH_MAX = 8'hff;

	localparam int CORNER_TL = 0;
	localparam int CORNER_TR = 1;
	localparam int CORNER_BL = 2;
	localparam int CORNER_BR = 3;

	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgba_t;

	function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] pix, input int k);
		return pix[k*CH_W +: CH_W];
	endfunction

endpackage

// ===== rtl/pbb_weight.sv =====
// Corner weights, alpha-weighted products and blended alpha sum.
module pbb_weight #(
	parameter int FRAC_BITS = pbb_pkg::DEF_FRAC_BITS,
	localparam int WA_W = 2 * FRAC_BITS + 8
) (
	input  logic                         clk,
	input  logic [pbb_pkg::PIX_W-1:0]    pix [pbb_pkg::CORNERS],
	input  logic [pbb_pkg::FRAC_W-1:0]   frac_x,
	input  logic [pbb_pkg::FRAC_W-1:0]   frac_y,
	output logic [pbb_pkg::PIX_W-1:0]    pix_s2 [pbb_pkg::CORNERS],
	output logic [WA_W-1:0]              wa_s2 [pbb_pkg::CORNERS],
	output logic [WA_W-1:0]              asum_s4
);
	import pbb_pkg::*;

	localparam int WGT_W = FRAC_BITS + 1;
	localparam int W_W   = 2 * FRAC_BITS + 1;

	logic [FRAC_W+FRAC_BITS-1:0] fx_wide;
	logic [FRAC_W+FRAC_BITS-1:0] fy_wide;
	logic [WGT_W-1:0]            fx1;
	logic [WGT_W-1:0]            fy1;
	logic [WGT_W-1:0]            ifx;
	logic [WGT_W-1:0]            ify;
	logic [W_W-1:0]              w [CORNERS];
	logic [W_W-1:0]              w_s1 [CORNERS];
	logic [PIX_W-1:0]            pix_s1 [CORNERS];
	logic [WA_W-1:0]             asum_c;
	logic [WA_W-1:0]             asum_s3;

	always_comb begin
		fx_wide = {{FRAC_BITS{1'b0}}, frac_x};
		fy_wide = {{FRAC_BITS{1'b0}}, frac_y};
		fx1 = {1'b0, fx_wide[FRAC_BITS-1:0]};
		fy1 = {1'b0, fy_wide[FRAC_BITS-1:0]};
		ifx = (WGT_W'(1) << FRAC_BITS) - fx1;
		ify = (WGT_W'(1) << FRAC_BITS) - fy1;
		w[CORNER_TL] = W_W'(ifx) * W_W'(ify);
		w[CORNER_TR] = W_W'(fx1) * W_W'(ify);
		w[CORNER_BL] = W_W'(ifx) * W_W'(fy1);
		w[CORNER_BR] = W_W'(fx1) * W_W'(fy1);
		asum_c = wa_s2[CORNER_TL] + wa_s2[CORNER_TR] + wa_s2[CORNER_BL] + wa_s2[CORNER_BR];
	end

	always_ff @(posedge clk) begin
		w_s1    <= w;
		pix_s1  <= pix;
		pix_s2  <= pix_s1;
		for (int i = 0; i < CORNERS; i++) begin
			wa_s2[i] <= WA_W'(w_s1[i]) * WA_W'(chan(pix_s1[i], ALPHA_IDX));
		end
		asum_s3 <= asum_c;
		asum_s4 <= asum_s3;
	end

endmodule

// ===== rtl/pbb_lane.sv =====
// One color lane: premultiplied weighted sum and pipelined rounding divide.
module pbb_lane #(
	parameter int FRAC_BITS = pbb_pkg::DEF_FRAC_BITS,
	localparam int WA_W = 2 * FRAC_BITS + 8
) (
	input  logic                         clk,
	input  logic [pbb_pkg::CH_W-1:0]     c_s2 [pbb_pkg::CORNERS],
	input  logic [WA_W-1:0]              wa_s2 [pbb_pkg::CORNERS],
	input  logic [WA_W-1:0]              asum_s4,
	output logic [pbb_pkg::QUOT_BITS-1:0] quot_s12
);
	import pbb_pkg::*;

	localparam int CSUM_W = 2 * FRAC_BITS + 16;
	localparam int NUM_W  = 2 * FRAC_BITS + 17;
	localparam int DEN_W  = WA_W + 1;

	logic [CSUM_W-1:0]    prod_s3 [CORNERS];
	logic [CSUM_W-1:0]    csum_s4;
	logic [NUM_W-1:0]     rem_in [QUOT_BITS];
	logic [DEN_W-1:0]     den_in [QUOT_BITS];
	logic [QUOT_BITS-1:0] q_in [QUOT_BITS];
	logic [NUM_W-1:0]     trial [QUOT_BITS];
	logic [NUM_W-1:0]     rem_s [QUOT_BITS];
	logic [DEN_W-1:0]     den_s [QUOT_BITS];
	logic [QUOT_BITS-1:0] quot_s [QUOT_BITS];

	always_comb begin
		for (int j = 0; j < QUOT_BITS; j++) begin
			if (j == 0) begin
				rem_in[j] = NUM_W'({csum_s4, 1'b0}) + NUM_W'(asum_s4);
				den_in[j] = {asum_s4, 1'b0};
				q_in[j]   = '0;
			end else begin
				rem_in[j] = rem_s[j-1];
				den_in[j] = den_s[j-1];
				q_in[j]   = quot_s[j-1];
			end
			trial[j] = NUM_W'(den_in[j]) << (QUOT_BITS - 1 - j);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CORNERS; i++) begin
			prod_s3[i] <= CSUM_W'(wa_s2[i]) * CSUM_W'(c_s2[i]);
		end
		csum_s4 <= prod_s3[CORNER_TL] + prod_s3[CORNER_TR] + prod_s3[CORNER_BL]
			+ prod_s3[CORNER_BR];
		for (int j = 0; j < QUOT_BITS; j++) begin
			den_s[j] <= den_in[j];
			if (rem_in[j] >= trial[j]) begin
				rem_s[j]  <= rem_in[j] - trial[j];
				quot_s[j] <= q_in[j] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - j));
			end else begin
				rem_s[j]  <= rem_in[j];
				quot_s[j] <= q_in[j];
			end
		end
	end

	assign quot_s12 = quot_s[QUOT_BITS-1];

endmodule

// ===== rtl/pbb_merge.sv =====
// Merge stage: rounded blended alpha, zero-alpha override and result word.
module pbb_merge #(
	parameter int FRAC_BITS = pbb_pkg::DEF_FRAC_BITS,
	localparam int WA_W = 2 * FRAC_BITS + 8
) (
	input  logic                          clk,
	input  logic [WA_W-1:0]               asum_s4,
	input  logic [pbb_pkg::QUOT_BITS-1:0] quot_s12 [pbb_pkg::COLORS],
	output pbb_pkg::rgba_t                px_s13
);
	import pbb_pkg::*;

	logic [WA_W:0]       rnd;
	logic [CH_W:0]       alpha_raw;
	logic [CH_W-1:0]     alpha;
	logic [CH_W-1:0]     alpha_s [QUOT_BITS];
	logic                zero_s [QUOT_BITS];

	always_comb begin
		rnd       = (WA_W + 1)'(asum_s4) + ((WA_W + 1)'(1) << (2 * FRAC_BITS - 1));
		alpha_raw = rnd[WA_W:2*FRAC_BITS];
		alpha     = (alpha_raw > (CH_W + 1)'(CH_MAX)) ? CH_MAX : alpha_raw[CH_W-1:0];
	end

	always_ff @(posedge clk) begin
		alpha_s[0] <= alpha;
		zero_s[0]  <= (asum_s4 == '0);
		for (int j = 1; j < QUOT_BITS; j++) begin
			alpha_s[j] <= alpha_s[j-1];
			zero_s[j]  <= zero_s[j-1];
		end
		px_s13.alpha <= alpha_s[QUOT_BITS-1];
		px_s13.red   <= zero_s[QUOT_BITS-1] ? '0 : CH_W'(quot_s12[0]);
		px_s13.green <= zero_s[QUOT_BITS-1] ? '0 : CH_W'(quot_s12[1]);
		px_s13.blue  <= zero_s[QUOT_BITS-1] ? '0 : CH_W'(quot_s12[2]);
	end

endmodule

// ===== rtl/premultiplied_bilinear_blend.sv =====
// Top level of the premultiplied bilinear RGBA blend with stream ports.
// Takes one sample (four RGBA8888 corners plus two weights) per transfer and
// returns one RGBA8888 pixel, blended on premultiplied color and converted back
// by the blended alpha with round-to-nearest. One sample is accepted every clock
// while fewer than 16 samples are outstanding. A result passes through three
// multiply stages, one summing stage, the eight-stage restoring divider in each
// color lane and the merge register before it reaches the output queue. Results
// wait in a 16-entry output queue; intake holds while 16 samples are outstanding,
// so output backpressure stalls the input once the queue and the pipeline
// together hold 16 samples. There is no setup or clearing phase after reset.
`include "premultiplied_bilinear_blend_defines.svh"
module premultiplied_bilinear_blend #(
	parameter int FRAC_BITS = pbb_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
	// frac_x, frac_y
	input  logic [pbb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [pbb_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
	import pbb_pkg::*;

	localparam int WA_W  = 2 * FRAC_BITS + 8;
	localparam int CNT_W = FIFO_AW + 1;

	logic [PIX_W-1:0]     pix [CORNERS];
	logic [FRAC_W-1:0]    frac_x;
	logic [FRAC_W-1:0]    frac_y;
	logic [PIX_W-1:0]     pix_s2 [CORNERS];
	logic [WA_W-1:0]      wa_s2 [CORNERS];
	logic [WA_W-1:0]      asum_s4;
	logic [CH_W-1:0]      c_s2 [COLORS][CORNERS];
	logic [QUOT_BITS-1:0] quot_s12 [COLORS];
	rgba_t                px_s13;

	logic [PIPE_LAT-1:0]  vld_q;
	rgba_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 acc;
	logic                 push;
	logic                 pop;

	always_comb begin
		for (int i = 0; i < CORNERS; i++) begin
			pix[i] = s_axis_tdata[i*PIX_W +: PIX_W];
		end
		frac_x = s_axis_tdata[CORNERS*PIX_W +: FRAC_W];
		frac_y = s_axis_tdata[CORNERS*PIX_W+FRAC_W +: FRAC_W];
		for (int k = 0; k < COLORS; k++) begin
			for (int i = 0; i < CORNERS; i++) begin
				c_s2[k][i] = chan(pix_s2[i], k);
			end
		end
	end

	pbb_weight #(
		.FRAC_BITS(FRAC_BITS)
	) u_weight (
		.clk    (clk),
		.pix    (pix),
		.frac_x (frac_x),
		.frac_y (frac_y),
		.pix_s2 (pix_s2),
		.wa_s2  (wa_s2),
		.asum_s4(asum_s4)
	);

	for (genvar k = 0; k < COLORS; k++) begin : g_lane
		pbb_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.c_s2    (c_s2[k]),
			.wa_s2   (wa_s2),
			.asum_s4 (asum_s4),
			.quot_s12(quot_s12[k])
		);
	end

	pbb_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.asum_s4 (asum_s4),
		.quot_s12(quot_s12),
		.px_s13  (px_s13)
	);

	assign s_axis_tready = (cnt_q < CNT_W'(FIFO_DEPTH));
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign push          = vld_q[PIPE_LAT-1];
	assign m_axis_tvalid = (fill_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			cnt_q    <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], acc};
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			fill_q <= fill_q + CNT_W'(push) - CNT_W'(pop);
			cnt_q  <= cnt_q + CNT_W'(acc) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= px_s13;
		end
	end

	`PBB_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(FIFO_DEPTH), "outstanding count exceeds queue depth")
	`PBB_ASSERT(a_fill_le_cnt, fill_q <= cnt_q, "queue holds more than was accepted")
	`PBB_ASSERT(a_no_overflow, push |-> (fill_q < CNT_W'(FIFO_DEPTH)), "output queue overflow")
	`PBB_ASSERT(a_accept_enters, acc |=> vld_q[0], "accepted transfer missing from pipeline")
	`PBB_ASSERT_NR(a_reset_idle, !arst_n |=> (cnt_q == '0 && fill_q == '0), "not idle in reset")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the premultiplied bilinear RGBA blend stream block.
`timescale 1ns / 100ps

module tb;
	import pbb_pkg::*;

	localparam int FB        = DEF_FRAC_BITS;
	localparam int N_RANDOM  = 1750;
	localparam int CHUNK     = 250;
	localparam int MAX_GAP   = 11;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [M_TDATA_W-1:0]   m_axis_tdata;

	bit src_idle_en;
	bit sink_idle_en;
	int samples_sent;

	premultiplied_bilinear_blend #(
		.FRAC_BITS(FB)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	class blend_scoreboard;
		rgba_t pixel_q[$];
		int    errors;
		int    pixels_checked;
		int    clear_pixels;

		function rgba_t blend_pixel(logic [S_TDATA_W-1:0] d);
			logic [63:0]      scale;
			logic [63:0]      fx;
			logic [63:0]      fy;
			logic [63:0]      wt[CORNERS];
			logic [63:0]      wa;
			logic [63:0]      asum;
			logic [63:0]      csum[COLORS];
			logic [63:0]      q;
			logic [PIX_W-1:0] corner;
			logic [CH_W-1:0]  lane[COLORS];
			rgba_t            r;
			scale = 64'd1 << FB;
			fx = 64'(d[CORNERS*PIX_W +: FRAC_W]) & (scale - 64'd1);
			fy = 64'(d[CORNERS*PIX_W+FRAC_W +: FRAC_W]) & (scale - 64'd1);
			wt[CORNER_TL] = (scale - fx) * (scale - fy);
			wt[CORNER_TR] = fx * (scale - fy);
			wt[CORNER_BL] = (scale - fx) * fy;
			wt[CORNER_BR] = fx * fy;
			asum = 0;
			for (int k = 0; k < COLORS; k++)
				csum[k] = 0;
			for (int i = 0; i < CORNERS; i++) begin
				corner = d[i*PIX_W +: PIX_W];
				wa = wt[i] * 64'(corner[ALPHA_IDX*CH_W +: CH_W]);
				asum += wa;
				for (int k = 0; k < COLORS; k++)
					csum[k] += wa * 64'(corner[k*CH_W +: CH_W]);
			end
			for (int k = 0; k < COLORS; k++) begin
				if (asum == 0) begin
					lane[k] = '0;
				end else begin
					q = (2 * csum[k] + asum) / (2 * asum);
					lane[k] = (q > 255) ? CH_MAX : q[CH_W-1:0];
				end
			end
			q = (asum + (64'd1 << (2 * FB - 1))) >> (2 * FB);
			r.red   = lane[0];
			r.green = lane[1];
			r.blue  = lane[2];
			r.alpha = (q > 255) ? CH_MAX : q[CH_W-1:0];
			return r;
		endfunction

		function void note_sample(logic [S_TDATA_W-1:0] d);
			pixel_q.push_back(blend_pixel(d));
		endfunction

		function void cmp(string name, logic [CH_W-1:0] e, logic [CH_W-1:0] a);
			if (a !== e) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_pixel(logic [M_TDATA_W-1:0] d);
			rgba_t got;
			rgba_t exp_px;
			got = rgba_t'(d);
			if (pixel_q.size() == 0) begin
				$error("unexpected pixel 0x%08h with nothing outstanding", d);
				errors++;
				return;
			end
			exp_px = pixel_q.pop_front();
			cmp("out_red",   exp_px.red,   got.red);
			cmp("out_green", exp_px.green, got.green);
			cmp("out_blue",  exp_px.blue,  got.blue);
			cmp("out_alpha", exp_px.alpha, got.alpha);
			pixels_checked++;
			if (exp_px.alpha == 0)
				clear_pixels++;
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction
	endclass

	blend_scoreboard sb = new();

	function automatic logic [S_TDATA_W-1:0] pack_sample(
		logic [PIX_W-1:0] tl, logic [PIX_W-1:0] tr,
		logic [PIX_W-1:0] bl, logic [PIX_W-1:0] br,
		logic [FRAC_W-1:0] fx, logic [FRAC_W-1:0] fy);
		return {fy, fx, br, bl, tr, tl};
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] p;
		p = $urandom();
		case ($urandom_range(0, 5))
			0: p[31:24] = 8'h00;
			1: p[31:24] = 8'hff;
			2: p[31:24] = 8'($urandom_range(1, 3));
			default: ;
		endcase
		return p;
	endfunction

	function automatic logic [FRAC_W-1:0] random_frac();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 8'h80;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [S_TDATA_W-1:0] random_sample();
		logic [S_TDATA_W-1:0] d;
		d = pack_sample(random_pixel(), random_pixel(), random_pixel(), random_pixel(),
			random_frac(), random_frac());
		if ($urandom_range(0, 19) == 0) begin
			for (int i = 0; i < CORNERS; i++)
				d[i*PIX_W + ALPHA_IDX*CH_W +: CH_W] = '0;
		end
		return d;
	endfunction

	task automatic send_sample(input logic [S_TDATA_W-1:0] d);
		int gap;
		gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(d);
		samples_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb: FAIL");
		$finish;
	end

	// sink: accept results with random stalls
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = sink_idle_en ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_pixel(m_axis_tdata);
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_idle_en   = 1'b1;
		sink_idle_en  = 1'b1;
		samples_sent  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners of the behavior
		send_sample(pack_sample('0, '0, '0, '0, '0, '0));
		send_sample(pack_sample('1, '1, '1, '1, '0, '0));
		send_sample(pack_sample('1, '1, '1, '1, '1, '1));
		send_sample(pack_sample('1, '1, '1, '1, 8'h80, 8'h80));
		send_sample(pack_sample(32'hff112233, 32'h00ffffff, 32'h00ffffff, 32'h00ffffff,
			8'h80, 8'h80));
		send_sample(pack_sample(32'h00ffffff, 32'hff445566, 32'h00ffffff, 32'h00ffffff,
			'1, '0));
		send_sample(pack_sample(32'h00ffffff, 32'h00ffffff, 32'hff778899, 32'h00ffffff,
			'0, '1));
		send_sample(pack_sample(32'h00ffffff, 32'h00ffffff, 32'h00ffffff, 32'hffaabbcc,
			'1, '1));
		send_sample(pack_sample(32'h01ffffff, 32'h00000000, 32'h00000000, 32'h00000000,
			'1, '1));
		send_sample(pack_sample(32'h01ff80ff, '0, '0, '0, '0, '0));
		send_sample(pack_sample(32'h80ff0000, 32'h8000ff00, 32'h800000ff, 32'h80ffffff,
			8'h80, 8'h80));
		send_sample(pack_sample(32'hff000000, 32'h00ffffff, 32'hff000000, 32'h00ffffff,
			8'h01, 8'h7f));
		send_sample(pack_sample(32'h7fffffff, 32'h80000000, 32'h01ff00ff, 32'hfe00ff00,
			8'h55, 8'haa));
		send_sample(pack_sample(32'h00ffffff, 32'h00ffffff, 32'h00ffffff, 32'h00ffffff,
			8'h3c, 8'hc3));
		send_sample(pack_sample(32'hffffffff, 32'h01000000, 32'h02010101, 32'h03fefefe,
			'1, 8'h01));
		send_sample(pack_sample(32'h80808080, 32'h7f7f7f7f, 32'h80808080, 32'h7f7f7f7f,
			8'h80, '0));
		send_sample(pack_sample(32'h02000001, 32'h02000002, '0, '0, 8'h80, '0));
		send_sample(pack_sample(32'hff0000ff, 32'hffff0000, 32'hff00ff00, 32'hffffffff,
			8'hff, 8'h00));

		// hold intake until the pipeline is empty
		drain();

		for (int c = 0; c < N_RANDOM / CHUNK; c++) begin
			src_idle_en  = c[0];
			sink_idle_en = c[1];
			for (int n = 0; n < CHUNK; n++)
				send_sample(random_sample());
			if (c == 3)
				drain();
		end
		s_axis_tvalid <= 1'b0;

		drain();
		repeat (PIPE_LAT + FIFO_DEPTH + 8) @(posedge clk);

		$display("tb: %0d samples sent, %0d pixels checked (%0d with zero blended alpha)",
			samples_sent, sb.pixels_checked, sb.clear_pixels);
		$display("tb: source and sink stalls run in all four on/off combinations");
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pbb_pkg.sv
rtl/pbb_weight.sv
rtl/pbb_lane.sv
rtl/pbb_merge.sv
rtl/premultiplied_bilinear_blend.sv
tb/tb.sv
